// ===== design/serial_line_editor_core_macros.svh =====
// ----------------------------------------------------------------------------
// serial_line_editor_core_macros.svh
// Assertion shorthands for the serial line editor checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_CORE_MACROS_SVH
`define SERIAL_LINE_EDITOR_CORE_MACROS_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define SLE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serial_line_editor_core check failed");

// next-cycle implication
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serial_line_editor_core check failed");

`endif

// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, types and helpers of the serial line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int IDX_W = $clog2(LINE_CAPACITY);
    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_LBR = 8'd91;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] CH_MAXP = 8'd125;
    localparam logic [7:0] CH_0   = 8'd48;

    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_ERROR   = 3'd1;
    localparam logic [2:0] ST_HANDLED = 3'd2;
    localparam logic [2:0] ST_PASS    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_SEEN = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;

    typedef struct packed {
        logic [7:0]       tx_byte;
        logic             tx_valid;
        logic [2:0]       status;
        logic [7:0]       pass_char;
        logic [7:0]       line_char;
        logic [LEN_W-1:0] line_length;
        logic             last;
    } sle_item_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } sle_ram_req_t;

    function automatic logic [2:0] dec_tens(logic [LEN_W-1:0] v);
        logic [2:0] t;
        t = 3'd0;
        if (7'(v) >= 7'd10) t = 3'd1;
        if (7'(v) >= 7'd20) t = 3'd2;
        if (7'(v) >= 7'd30) t = 3'd3;
        if (7'(v) >= 7'd40) t = 3'd4;
        return t;
    endfunction

    function automatic logic [7:0] dec_ones(logic [LEN_W-1:0] v);
        logic [6:0] r;
        r = 7'(v) - 7'(dec_tens(v)) * 7'd10;
        return CH_0 + 8'(r);
    endfunction

endpackage

`default_nettype wire

// ===== design/sle_ram.sv =====
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sle_engine.sv =====
// ----------------------------------------------------------------------------
// sle_engine
// Key decoder and sequencer: shifts line entries in the RAM and streams the
// bytes for the terminal one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic                          in_mode,
    input  wire logic [7:0]                    in_key,
    input  wire logic [4:0]                    in_index,
    output logic                               in_ready,
    input  wire logic                          out_free,
    output logic                               out_valid,
    output sle_pkg::sle_item_t                 out_item,
    output sle_pkg::sle_ram_req_t              ram_req,
    input  wire logic [7:0]                    ram_rdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SHRD  = 4'd1;
    localparam logic [3:0] S_SHWR  = 4'd2;
    localparam logic [3:0] S_PRE   = 4'd3;
    localparam logic [3:0] S_STRD  = 4'd4;
    localparam logic [3:0] S_STEM  = 4'd5;
    localparam logic [3:0] S_SUF   = 4'd6;
    localparam logic [3:0] S_NULL  = 4'd7;
    localparam logic [3:0] S_RDW   = 4'd8;

    localparam int LW = sle_pkg::LEN_W;
    localparam int IW = sle_pkg::IDX_W;
    localparam logic [LW-1:0] CAP = LW'(sle_pkg::LINE_CAPACITY);

    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] cursor_reg, cursor_next;
    logic [LW-1:0] length_reg, length_next;
    logic [1:0]    esc_reg, esc_next;
    logic [7:0]    pre_reg [6];
    logic [7:0]    pre_next [6];
    logic [2:0]    pre_cnt_reg, pre_cnt_next, pre_idx_reg, pre_idx_next;
    logic [2:0]    suf_cnt_reg, suf_cnt_next, suf_idx_reg, suf_idx_next;
    logic [LW-1:0] st_ptr_reg, st_ptr_next, st_end_reg, st_end_next;
    logic [LW-1:0] sh_ptr_reg, sh_ptr_next, sh_end_reg, sh_end_next;
    logic          sh_left_reg, sh_left_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    pass_reg, pass_next;
    logic [7:0]    lchar_reg, lchar_next;

    logic [7:0] suf_byte;
    logic       stream_more;
    logic       is_last;

    // suffix is "ESC [ K" optionally followed by "ESC [ u"
    always_comb begin
        case (suf_idx_reg)
            3'd0, 3'd3: suf_byte = sle_pkg::CH_ESC;
            3'd1, 3'd4: suf_byte = sle_pkg::CH_LBR;
            3'd2:       suf_byte = 8'h4B;
            default:    suf_byte = 8'h75;
        endcase
    end

    assign stream_more = (st_ptr_reg != st_end_reg);
    assign in_ready    = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        length_next  = length_reg;
        esc_next     = esc_reg;
        for (int i = 0; i < 6; i++) pre_next[i] = pre_reg[i];
        pre_cnt_next = pre_cnt_reg;
        pre_idx_next = pre_idx_reg;
        suf_cnt_next = suf_cnt_reg;
        suf_idx_next = suf_idx_reg;
        st_ptr_next  = st_ptr_reg;
        st_end_next  = st_end_reg;
        sh_ptr_next  = sh_ptr_reg;
        sh_end_next  = sh_end_reg;
        sh_left_next = sh_left_reg;
        rd_ok_next   = rd_ok_reg;
        status_next  = status_reg;
        pass_next    = pass_reg;
        lchar_next   = lchar_reg;
        ram_req      = '0;
        out_valid    = 1'b0;
        is_last      = 1'b0;
        out_item     = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    pre_cnt_next = 3'd0;
                    pre_idx_next = 3'd0;
                    suf_cnt_next = 3'd0;
                    suf_idx_next = 3'd0;
                    st_ptr_next  = '0;
                    st_end_next  = '0;
                    sh_ptr_next  = '0;
                    sh_end_next  = '0;
                    pass_next    = 8'd0;
                    lchar_next   = 8'd0;
                    state_next   = S_SHRD;
                    if (in_mode) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = IW'(in_index);
                        rd_ok_next    = (7'(in_index) < 7'(CAP));
                        status_next   = sle_pkg::ST_READ;
                        state_next    = S_RDW;
                    end else if (in_key == sle_pkg::CH_ESC) begin
                        esc_next    = sle_pkg::ESC_SEEN;
                        status_next = sle_pkg::ST_PENDING;
                    end else if (esc_reg == sle_pkg::ESC_SEEN) begin
                        esc_next    = sle_pkg::ESC_NONE;
                        status_next = sle_pkg::ST_HANDLED;
                        if (in_key == sle_pkg::CH_LBR) begin
                            esc_next    = sle_pkg::ESC_CSI;
                            status_next = sle_pkg::ST_PENDING;
                        end else if (in_key == 8'h63) begin
                            // clear screen: ESC [ H ESC [ J
                            pre_next[0] = sle_pkg::CH_ESC;
                            pre_next[1] = sle_pkg::CH_LBR;
                            pre_next[2] = 8'h48;
                            pre_next[3] = sle_pkg::CH_ESC;
                            pre_next[4] = sle_pkg::CH_LBR;
                            pre_next[5] = 8'h4A;
                            pre_cnt_next = 3'd6;
                            cursor_next  = '0;
                            length_next  = '0;
                        end else if (in_key == 8'h70) begin
                            // reprint: CR, line, ESC [ K
                            pre_next[0]  = sle_pkg::CH_CR;
                            pre_cnt_next = 3'd1;
                            st_end_next  = length_reg;
                            suf_cnt_next = 3'd3;
                            cursor_next  = length_reg;
                        end else begin
                            status_next = sle_pkg::ST_ERROR;
                        end
                    end else if (esc_reg != sle_pkg::ESC_NONE) begin
                        esc_next    = sle_pkg::ESC_NONE;
                        status_next = sle_pkg::ST_HANDLED;
                        case (in_key)
                            8'h44: begin
                                if (cursor_reg != '0) begin
                                    cursor_next  = cursor_reg - 1'b1;
                                    pre_next[0]  = sle_pkg::CH_ESC;
                                    pre_next[1]  = sle_pkg::CH_LBR;
                                    pre_next[2]  = 8'h44;
                                    pre_cnt_next = 3'd3;
                                end
                            end
                            8'h43: begin
                                if (cursor_reg < length_reg) begin
                                    cursor_next  = cursor_reg + 1'b1;
                                    pre_next[0]  = sle_pkg::CH_ESC;
                                    pre_next[1]  = sle_pkg::CH_LBR;
                                    pre_next[2]  = 8'h43;
                                    pre_cnt_next = 3'd3;
                                end
                            end
                            8'h31: begin
                                cursor_next  = '0;
                                pre_next[0]  = sle_pkg::CH_CR;
                                pre_cnt_next = 3'd1;
                            end
                            8'h32: begin
                                if (length_reg < CAP) begin
                                    // open a slot: shift right, then redraw tail
                                    sh_left_next = 1'b0;
                                    sh_ptr_next  = length_reg;
                                    sh_end_next  = cursor_reg;
                                    if (cursor_reg == length_reg) begin
                                        ram_req.we    = 1'b1;
                                        ram_req.waddr = cursor_reg[IW-1:0];
                                        ram_req.wdata = 8'd0;
                                    end
                                    length_next  = length_reg + 1'b1;
                                    pre_next[0]  = sle_pkg::CH_ESC;
                                    pre_next[1]  = sle_pkg::CH_LBR;
                                    pre_next[2]  = 8'h73;
                                    pre_cnt_next = 3'd3;
                                    st_ptr_next  = cursor_reg;
                                    st_end_next  = length_reg + 1'b1;
                                    suf_cnt_next = 3'd6;
                                end
                            end
                            8'h34: begin
                                // go to end: CR ESC [ n C
                                cursor_next = length_reg;
                                pre_next[0] = sle_pkg::CH_CR;
                                pre_next[1] = sle_pkg::CH_ESC;
                                pre_next[2] = sle_pkg::CH_LBR;
                                if (7'(length_reg) >= 7'd10) begin
                                    pre_next[3]  = sle_pkg::CH_0
                                                 + 8'(sle_pkg::dec_tens(length_reg));
                                    pre_next[4]  = sle_pkg::dec_ones(length_reg);
                                    pre_next[5]  = 8'h43;
                                    pre_cnt_next = 3'd6;
                                end else begin
                                    pre_next[3]  = sle_pkg::dec_ones(length_reg);
                                    pre_next[4]  = 8'h43;
                                    pre_cnt_next = 3'd5;
                                end
                            end
                            default: begin
                                status_next = sle_pkg::ST_ERROR;
                            end
                        endcase
                    end else if (in_key == sle_pkg::CH_BS) begin
                        status_next = sle_pkg::ST_HANDLED;
                        if (cursor_reg != '0) begin
                            cursor_next  = cursor_reg - 1'b1;
                            length_next  = length_reg - 1'b1;
                            sh_left_next = 1'b1;
                            sh_ptr_next  = cursor_reg - 1'b1;
                            sh_end_next  = length_reg - 1'b1;
                            pre_next[0]  = sle_pkg::CH_ESC;
                            pre_next[1]  = sle_pkg::CH_LBR;
                            pre_next[2]  = 8'h44;
                            pre_next[3]  = sle_pkg::CH_ESC;
                            pre_next[4]  = sle_pkg::CH_LBR;
                            pre_next[5]  = 8'h73;
                            pre_cnt_next = 3'd6;
                            st_ptr_next  = cursor_reg - 1'b1;
                            st_end_next  = length_reg - 1'b1;
                            suf_cnt_next = 3'd6;
                        end
                    end else if (in_key == sle_pkg::CH_DEL) begin
                        status_next = sle_pkg::ST_HANDLED;
                        if (cursor_reg < length_reg) begin
                            length_next  = length_reg - 1'b1;
                            sh_left_next = 1'b1;
                            sh_ptr_next  = cursor_reg;
                            sh_end_next  = length_reg - 1'b1;
                            pre_next[0]  = sle_pkg::CH_ESC;
                            pre_next[1]  = sle_pkg::CH_LBR;
                            pre_next[2]  = 8'h73;
                            pre_cnt_next = 3'd3;
                            st_ptr_next  = cursor_reg;
                            st_end_next  = length_reg - 1'b1;
                            suf_cnt_next = 3'd6;
                        end
                    end else if (in_key < sle_pkg::CH_ESC || in_key > sle_pkg::CH_MAXP) begin
                        status_next = sle_pkg::ST_PASS;
                        pass_next   = in_key;
                    end else begin
                        status_next = sle_pkg::ST_HANDLED;
                        if (cursor_reg < CAP) begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = cursor_reg[IW-1:0];
                            ram_req.wdata = in_key;
                            pre_next[0]   = in_key;
                            pre_cnt_next  = 3'd1;
                            cursor_next   = cursor_reg + 1'b1;
                            if (cursor_reg + 1'b1 > length_reg) begin
                                length_next = cursor_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            S_RDW: begin
                lchar_next = rd_ok_reg ? ram_rdata : 8'd0;
                state_next = S_NULL;
            end
            S_SHRD: begin
                if (sh_ptr_reg == sh_end_reg) begin
                    if (pre_cnt_reg != 3'd0)      state_next = S_PRE;
                    else if (stream_more)         state_next = S_STRD;
                    else if (suf_cnt_reg != 3'd0) state_next = S_SUF;
                    else                          state_next = S_NULL;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = sh_left_reg ? IW'(sh_ptr_reg + 1'b1)
                                                : IW'(sh_ptr_reg - 1'b1);
                    state_next    = S_SHWR;
                end
            end
            S_SHWR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sh_ptr_reg[IW-1:0];
                ram_req.wdata = ram_rdata;
                sh_ptr_next   = sh_left_reg ? sh_ptr_reg + 1'b1 : sh_ptr_reg - 1'b1;
                state_next    = S_SHRD;
            end
            S_PRE: begin
                is_last = (pre_idx_reg == pre_cnt_reg - 3'd1) && !stream_more
                          && (suf_cnt_reg == 3'd0);
                out_item.tx_byte = pre_reg[pre_idx_reg];
                if (out_free) begin
                    out_valid    = 1'b1;
                    pre_idx_next = pre_idx_reg + 3'd1;
                    if (pre_idx_reg == pre_cnt_reg - 3'd1) begin
                        if (stream_more)              state_next = S_STRD;
                        else if (suf_cnt_reg != 3'd0) state_next = S_SUF;
                        else                          state_next = S_IDLE;
                    end
                end
            end
            S_STRD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = st_ptr_reg[IW-1:0];
                state_next    = S_STEM;
            end
            S_STEM: begin
                is_last = (st_ptr_reg + 1'b1 == st_end_reg) && (suf_cnt_reg == 3'd0);
                out_item.tx_byte = ram_rdata;
                if (out_free) begin
                    out_valid   = 1'b1;
                    st_ptr_next = st_ptr_reg + 1'b1;
                    if (st_ptr_reg + 1'b1 != st_end_reg) state_next = S_STRD;
                    else if (suf_cnt_reg != 3'd0)        state_next = S_SUF;
                    else                                 state_next = S_IDLE;
                end
            end
            S_SUF: begin
                is_last = (suf_idx_reg == suf_cnt_reg - 3'd1);
                out_item.tx_byte = suf_byte;
                if (out_free) begin
                    out_valid    = 1'b1;
                    suf_idx_next = suf_idx_reg + 3'd1;
                    if (is_last) state_next = S_IDLE;
                end
            end
            S_NULL: begin
                is_last = 1'b1;
                if (out_free) begin
                    out_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_item.tx_valid    = (state_reg != S_NULL);
        out_item.line_length = length_reg;
        out_item.last        = is_last;
        out_item.status      = is_last ? status_reg : sle_pkg::ST_PENDING;
        out_item.pass_char   = (is_last && status_reg == sle_pkg::ST_PASS) ? pass_reg : 8'd0;
        out_item.line_char   = (is_last && status_reg == sle_pkg::ST_READ) ? lchar_reg : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            length_reg <= '0;
            esc_reg    <= sle_pkg::ESC_NONE;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            esc_reg    <= esc_next;
        end
        for (int i = 0; i < 6; i++) pre_reg[i] <= pre_next[i];
        pre_cnt_reg <= pre_cnt_next;
        pre_idx_reg <= pre_idx_next;
        suf_cnt_reg <= suf_cnt_next;
        suf_idx_reg <= suf_idx_next;
        st_ptr_reg  <= st_ptr_next;
        st_end_reg  <= st_end_next;
        sh_ptr_reg  <= sh_ptr_next;
        sh_end_reg  <= sh_end_next;
        sh_left_reg <= sh_left_next;
        rd_ok_reg   <= rd_ok_next;
        status_reg  <= status_next;
        pass_reg    <= pass_next;
        lchar_reg   <= lchar_next;
    end

endmodule

`default_nettype wire

// ===== design/serial_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor_core
// Terminal-style edit line: key bytes in, terminal bytes and status out.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time; s_tready is high only while the
// sequencer is idle. Each input yields one output transaction per byte sent to
// the terminal (or one with tx_valid low if nothing is sent), with status on
// the transaction that has tlast set. Each input is decoded; then each line
// entry moved by a backspace, delete or insert is read from the line RAM and
// written back (the read data is registered), the entry move is closed, and
// the fixed escape bytes and the line entries streamed out of the RAM follow,
// each entry read and then sent; any m_tready stall holds the output. Worst
// case is a backspace at position 1 of a full line. A result register on
// the m_ side lets the sequencer keep working while the last result waits.
// The line RAM is not cleared; edits only read entries after the line has
// covered them, but a line read may return an entry past the line length.
`default_nettype none

module serial_line_editor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] key_byte, [12:8] read_index, rest 0
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [7:0] tx_byte, [10:8] status, [18:11] pass_char,
                                        // [26:19] line_char, [32:27] line_length, rest 0
    output logic             m_tuser,   // [0] tx_valid
    output logic             m_tlast
);

    sle_pkg::sle_item_t    eng_item;
    sle_pkg::sle_item_t    item_reg;
    sle_pkg::sle_ram_req_t ram_req;
    logic                  eng_valid;
    logic                  out_free;
    logic                  m_tvalid_reg;
    logic [7:0]            ram_rdata;

    // result register can take a new item when empty or draining this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    sle_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_key    (s_tdata[7:0]),
        .in_index  (s_tdata[12:8]),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .out_valid (eng_valid),
        .out_item  (eng_item),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    sle_ram #(
        .WIDTH (8),
        .DEPTH (sle_pkg::LINE_CAPACITY)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= eng_valid;
        end
        if (out_free && eng_valid) begin
            item_reg <= eng_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = item_reg.tx_valid;
    assign m_tlast  = item_reg.last;
    assign m_tdata  = {7'd0, 6'(item_reg.line_length), item_reg.line_char,
                       item_reg.pass_char, item_reg.status, item_reg.tx_byte};

endmodule

`default_nettype wire

// ===== design/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks of the serial line editor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_line_editor_core_macros.svh"

module sle_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `SLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `SLE_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `SLE_ASSERT_SAME(a_null_byte, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)
    `SLE_ASSERT_SAME(a_status_on_last, m_tvalid && !m_tlast, m_tdata[26:8] == 19'd0)
    `SLE_ASSERT_SAME(a_len_range, m_tvalid, m_tdata[32:27] <= 6'(sle_pkg::LINE_CAPACITY))

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (.*);

`default_nettype wire
